// ----- rtl/core/aldr_pkg.sv -----
// Package for the ambient light dimmer ramp block.
// Holds shared constants, register codes, structs and byte/flag helpers.
// No dependencies; compiled first.
package aldr_pkg;

    localparam int LAMP_COUNT_DEF = 4;
    localparam int PACKED_LAMPS   = 4;

    localparam logic [4:0] NIGHT_CLEAR_HOUR   = 5'd5;
    localparam logic [4:0] NIGHT_DISABLE_HOUR = 5'd12;
    localparam logic [6:0] FULL_LEVEL         = 7'd100;
    localparam logic [7:0] DARK_LIMIT         = 8'd10;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FORCE_FLAGS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_HOUR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MINUTE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DELAY    = 3'd6;

    typedef struct packed {
        logic [7:0]  force_flags;
        logic [7:0]  start_light_level;
        logic [31:0] standby_levels;
        logic [31:0] max_levels;
        logic [4:0]  off_hour;
        logic [5:0]  off_minute;
        logic [15:0] ramp_delay_ms;
    } cfg_regs_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [7:0] packed_byte(logic [31:0] word, logic [3:0] idx);
        logic [7:0] b;
        b = '0;
        if (idx < 4'(PACKED_LAMPS))
        begin
            b = word[{idx[1:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic full_bit(logic [7:0] flags, logic [3:0] idx);
        logic f;
        f = 1'b0;
        if (idx < 4'(PACKED_LAMPS))
        begin
            f = flags[3'(3'd7 - idx[2:0])];
        end
        return f;
    endfunction

    function automatic logic off_bit(logic [7:0] flags, logic [3:0] idx);
        logic f;
        f = 1'b0;
        if (idx < 4'(PACKED_LAMPS))
        begin
            f = flags[3'(3'd3 - idx[2:0])];
        end
        return f;
    endfunction

endpackage

// ----- rtl/core/aldr_if.sv -----
// Handshake interfaces for the scan input, the result output and the
// configuration write channel. The index width is written out as 3 bits here.
interface aldr_scan_if;
    logic        valid;
    logic        ready;
    logic [7:0]  light_sensor;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [31:0] now_ms;

    modport source (output valid, light_sensor, clock_hour, clock_minute, now_ms,
                    input ready);
    modport sink   (input valid, light_sensor, clock_hour, clock_minute, now_ms,
                    output ready);
    modport mon    (input valid, ready, light_sensor, clock_hour, clock_minute, now_ms);
endinterface

interface aldr_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] level_0;
    logic [6:0] level_1;
    logic [6:0] level_2;
    logic [6:0] level_3;
    logic       night_active;

    modport source (output valid, level_0, level_1, level_2, level_3, night_active,
                    input ready);
    modport sink   (input valid, level_0, level_1, level_2, level_3, night_active,
                    output ready);
    modport mon    (input valid, ready, level_0, level_1, level_2, level_3, night_active);
endinterface

interface aldr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- rtl/core/aldr_cfg_regs.sv -----
// Configuration register file of the dimmer ramp block.
// Decodes write words from the configuration channel; depends on aldr_pkg.
module aldr_cfg_regs
    import aldr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    aldr_cfg_if.sink        cfg,
    output cfg_regs_t       regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                REG_FORCE_FLAGS: regs_next.force_flags       = cfg.wr_data[7:0];
                REG_START_LEVEL: regs_next.start_light_level = cfg.wr_data[7:0];
                REG_STANDBY:     regs_next.standby_levels    = cfg.wr_data;
                REG_MAX_LEVELS:  regs_next.max_levels        = cfg.wr_data;
                REG_OFF_HOUR:    regs_next.off_hour          = cfg.wr_data[4:0];
                REG_OFF_MINUTE:  regs_next.off_minute        = cfg.wr_data[5:0];
                REG_RAMP_DELAY:  regs_next.ramp_delay_ms     = cfg.wr_data[15:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.force_flags       <= '0;
            regs_reg.start_light_level <= '0;
            regs_reg.standby_levels    <= '0;
            regs_reg.max_levels        <= '1;
            regs_reg.off_hour          <= NIGHT_DISABLE_HOUR;
            regs_reg.off_minute        <= '0;
            regs_reg.ramp_delay_ms     <= 16'd20;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/core/aldr_div.sv -----
// Shared serial divider: 16-bit dividend by 8-bit divisor, one quotient bit
// per cycle, for dividends whose high byte is below the divisor. Uses aldr_pkg.
module aldr_div
    import aldr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  div_ctl_t   ctl,
    output div_stat_t  stat,
    output logic [7:0] quotient
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] div_reg, div_next;
    logic [8:0] trial;
    logic [8:0] diff;

    assign trial = {rem_reg, low_reg[7]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = ctl.dividend[15:8];
            low_next  = ctl.dividend[7:0];
            div_next  = ctl.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[6:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[7:0];
                quo_next = {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- rtl/core/ambient_light_dimmer_ramp_top.sv -----
// Top level of the ambient light dimmer ramp; uses aldr_pkg, aldr_if, aldr_cfg_regs, aldr_div.
// A scan accepts its word, then for each lamp forms the target and updates the level; when the
// scaled target needs the serial divider, the divider is started, its 8 quotient bits are formed
// and the quotient is picked up before the update. The block takes one scan at a time.
// The result word waits in an output register; a full register holds the next scan back.
// Reset is asynchronous; levels, step times, night flag and result valid clear.
module ambient_light_dimmer_ramp_top
    import aldr_pkg::*;
#(
    parameter int LAMP_COUNT = LAMP_COUNT_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    aldr_scan_if.sink      scan,
    aldr_result_if.source  result,
    aldr_cfg_if.sink       cfg
);

    localparam int LIDX_W = (LAMP_COUNT > 1) ? $clog2(LAMP_COUNT) : 1;
    localparam logic [LIDX_W-1:0] LAST_LAMP = LIDX_W'(LAMP_COUNT - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TGT  = 3'd1;
    localparam logic [2:0] ST_DIVW = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    cfg_regs_t  regs;
    div_ctl_t   div_ctl;
    div_stat_t  div_stat;
    logic [7:0] quotient;

    logic [2:0]        state_reg, state_next;
    logic [LIDX_W-1:0] lamp_reg, lamp_next;
    logic              night_reg, night_next;
    logic [7:0]        sensor_reg, sensor_next;
    logic [31:0]       now_reg, now_next;
    logic [6:0]        base_reg, base_next;
    logic [6:0]        level_reg [LAMP_COUNT];
    logic [6:0]        level_next [LAMP_COUNT];
    logic [31:0]       step_reg [LAMP_COUNT];
    logic [31:0]       step_next [LAMP_COUNT];
    logic              res_valid_reg, res_valid_next;
    logic [6:0]        res_level_reg [PACKED_LAMPS];
    logic [6:0]        res_level_next [PACKED_LAMPS];
    logic              res_night_reg, res_night_next;
    logic [6:0]        snap [PACKED_LAMPS];

    logic [3:0]  lamp_ext;
    logic [7:0]  gain;
    logic [7:0]  cap;
    logic [7:0]  start_lvl;
    logic [7:0]  scale_diff;
    logic        scaled;
    logic        night_scan;
    logic [7:0]  tgt;
    logic [6:0]  cur_level;
    logic [31:0] elapsed;

    aldr_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    aldr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign lamp_ext   = 4'(lamp_reg);
    assign gain       = packed_byte(regs.standby_levels, lamp_ext);
    assign cap        = packed_byte(regs.max_levels, lamp_ext);
    assign start_lvl  = regs.start_light_level;
    assign scale_diff = start_lvl - sensor_reg;
    assign scaled     = (start_lvl != 8'd0) && (gain != 8'd0);
    assign cur_level  = level_reg[lamp_reg];
    assign elapsed    = now_reg - step_reg[lamp_reg];

    assign div_ctl.start    = (state_reg == ST_TGT) && scaled && (sensor_reg < start_lvl);
    assign div_ctl.dividend = 16'({8'b0, scale_diff} * {8'b0, gain});
    assign div_ctl.divisor  = start_lvl;

    assign scan.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        night_scan = night_reg;
        if (scan.clock_hour == NIGHT_CLEAR_HOUR)
        begin
            night_scan = 1'b0;
        end
        if ((scan.clock_hour == regs.off_hour) && (scan.clock_minute >= regs.off_minute))
        begin
            night_scan = 1'b1;
        end
        if (regs.off_hour == NIGHT_DISABLE_HOUR)
        begin
            night_scan = 1'b0;
        end
    end

    always_comb
    begin
        tgt = {1'b0, base_reg};
        if (night_reg)
        begin
            tgt = '0;
        end
        if (full_bit(regs.force_flags, lamp_ext))
        begin
            tgt = {1'b0, FULL_LEVEL};
        end
        else if (off_bit(regs.force_flags, lamp_ext))
        begin
            tgt = '0;
        end
        if (tgt > cap)
        begin
            tgt = cap;
        end
    end

    for (genvar k = 0; k < PACKED_LAMPS; k++)
    begin : g_snap
        if (k < LAMP_COUNT)
        begin : g_lamp
            assign snap[k] = level_reg[k];
        end
        else
        begin : g_none
            assign snap[k] = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lamp_next      = lamp_reg;
        night_next     = night_reg;
        sensor_next    = sensor_reg;
        now_next       = now_reg;
        base_next      = base_reg;
        level_next     = level_reg;
        step_next      = step_reg;
        res_level_next = res_level_reg;
        res_night_next = res_night_reg;
        res_valid_next = res_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (scan.valid)
                begin
                    night_next  = night_scan;
                    sensor_next = scan.light_sensor;
                    now_next    = scan.now_ms;
                    lamp_next   = '0;
                    state_next  = ST_TGT;
                end
            end
            ST_TGT:
            begin
                if (scaled)
                begin
                    if (sensor_reg >= start_lvl)
                    begin
                        base_next  = '0;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        state_next = ST_DIVW;
                    end
                end
                else
                begin
                    base_next  = (sensor_reg <= DARK_LIMIT) ? FULL_LEVEL : 7'd0;
                    state_next = ST_UPD;
                end
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    base_next  = (quotient > {1'b0, FULL_LEVEL}) ? FULL_LEVEL
                                                                 : quotient[6:0];
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if ((tgt != {1'b0, cur_level}) && (elapsed >= {16'b0, regs.ramp_delay_ms}))
                begin
                    step_next[lamp_reg] = now_reg;
                    if (tgt > {1'b0, cur_level})
                    begin
                        level_next[lamp_reg] = cur_level + 7'd1;
                    end
                    else
                    begin
                        level_next[lamp_reg] = cur_level - 7'd1;
                    end
                end
                if (lamp_reg == LAST_LAMP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lamp_next  = lamp_reg + LIDX_W'(1);
                    state_next = ST_TGT;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_level_next = snap;
                    res_night_next = night_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lamp_reg      <= '0;
            night_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LAMP_COUNT; i++)
            begin
                level_reg[i] <= '0;
                step_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            lamp_reg      <= lamp_next;
            night_reg     <= night_next;
            res_valid_reg <= res_valid_next;
            level_reg     <= level_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sensor_reg    <= sensor_next;
        now_reg       <= now_next;
        base_reg      <= base_next;
        res_level_reg <= res_level_next;
        res_night_reg <= res_night_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.level_0      = res_level_reg[0];
    assign result.level_1      = res_level_reg[1];
    assign result.level_2      = res_level_reg[2];
    assign result.level_3      = res_level_reg[3];
    assign result.night_active = res_night_reg;

endmodule

// ----- rtl/core/aldr_checker.sv -----
// Port-level checker for the dimmer ramp top level, bound to it below.
// Depends on aldr_pkg; sees the scan and result channels as plain signals.
module aldr_checker
    import aldr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    input  logic       scan_ready,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [6:0] level_0,
    input  logic [6:0] level_1,
    input  logic [6:0] level_2,
    input  logic [6:0] level_3,
    input  logic       night_active
);

    logic scan_acc;

    assign scan_acc = scan_valid && scan_ready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        scan_acc |=> !scan_ready)
        else $error("scan port stayed ready right after a word was accepted");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        scan_acc |=> !$rose(res_valid))
        else $error("result word appeared one cycle after a scan");

    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (level_0 <= FULL_LEVEL) && (level_1 <= FULL_LEVEL)
                   && (level_2 <= FULL_LEVEL) && (level_3 <= FULL_LEVEL))
        else $error("lamp level above full intensity");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(level_0)
            && $stable(level_1) && $stable(level_2)
            && $stable(level_3) && $stable(night_active)))
        else $error("stalled result word changed");

endmodule

bind ambient_light_dimmer_ramp_top aldr_checker u_aldr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_valid   (scan.valid),
    .scan_ready   (scan.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .level_0      (result.level_0),
    .level_1      (result.level_1),
    .level_2      (result.level_2),
    .level_3      (result.level_3),
    .night_active (result.night_active)
);
